// ----- hdl/ovb_pkg.sv -----
// Shared types and constants for the overlap linear blend block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps

package ovb_pkg;

  localparam int COLUMN_BITS_DEF = 12;
  localparam int PIXEL_BITS = 8;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_OVERLAP_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLEND_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_IMAGE = 2'd2;

  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

  typedef enum logic [1:0] {
    SEL_SRC,
    SEL_DST,
    SEL_MIX
  } sel_t;

  typedef struct packed {
    sel_t                  sel;
    logic [PIXEL_BITS-1:0] src;
    logic [PIXEL_BITS-1:0] dst;
    logic                  neg;
  } side_t;

endpackage

// ----- hdl/ovb_front.sv -----
// Front end: band classification, column distance and the two weight products.
// Two register stages with per-stage valid; uses ovb_pkg.
`timescale 1ns / 1ps

module ovb_front #(
  parameter int COLUMN_BITS = ovb_pkg::COLUMN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ovb_pkg::PIXEL_BITS-1:0]              src,
  input  logic [ovb_pkg::PIXEL_BITS-1:0]              dst,
  input  logic [COLUMN_BITS-1:0]                      col,
  input  logic [COLUMN_BITS-1:0]                      overlap,
  input  logic [COLUMN_BITS-1:0]                      blend,
  input  logic                                        first,
  output logic                                        prod_valid,
  input  logic                                        prod_ready,
  output logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  prod_a,
  output logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  prod_b,
  output ovb_pkg::side_t                              prod_side
);

  localparam int QW = ovb_pkg::PIXEL_BITS + COLUMN_BITS;
  localparam int SW = COLUMN_BITS + 2;

  logic signed [SW-1:0] ov_s;
  logic signed [SW-1:0] bl_s;
  logic signed [SW-1:0] col_s;
  logic signed [SW-1:0] band_lo;
  logic signed [SW-1:0] band_hi;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] mag_full;
  ovb_pkg::sel_t        sel;
  logic                 neg;

  logic                   s1_valid;
  logic                   s1_ready;
  logic [COLUMN_BITS-1:0] s1_col;
  logic [COLUMN_BITS-1:0] s1_mag;
  ovb_pkg::side_t         s1_side;
  logic                   s2_ready;

  assign ov_s = signed'(SW'(overlap));
  assign bl_s = signed'(SW'(blend));
  assign col_s = signed'(SW'(col));
  assign band_lo = (ov_s - bl_s) >>> 1;
  assign band_hi = (ov_s + bl_s) >>> 1;
  assign diff = ov_s - col_s;
  assign neg = diff[SW-1];
  assign mag_full = neg ? -diff : diff;

  always_comb begin
    if (first) begin
      sel = ovb_pkg::SEL_SRC;
    end else if (col_s < band_lo) begin
      sel = ovb_pkg::SEL_DST;
    end else if (col_s < band_hi) begin
      sel = (overlap == '0) ? ovb_pkg::SEL_SRC : ovb_pkg::SEL_MIX;
    end else begin
      sel = ovb_pkg::SEL_SRC;
    end
  end

  assign s2_ready = !prod_valid || prod_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_col <= col;
      s1_mag <= mag_full[COLUMN_BITS-1:0];
      s1_side.sel <= sel;
      s1_side.src <= src;
      s1_side.dst <= dst;
      s1_side.neg <= neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (s2_ready) begin
      prod_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      prod_a <= QW'(s1_side.src) * QW'(s1_col);
      prod_b <= QW'(s1_side.dst) * QW'(s1_mag);
      prod_side <= s1_side;
    end
  end

  a_first_copies : assert property (@(posedge clk) disable iff (rst)
    (in_valid && s1_ready && first) |=> (s1_side.sel == ovb_pkg::SEL_SRC))
    else $error("first image beat not classified as copy");

  a_prod_holds : assert property (@(posedge clk) disable iff (rst)
    (prod_valid && !prod_ready) |=> (prod_valid && $stable(prod_a) && $stable(prod_b)))
    else $error("product stage changed while held");

endmodule

// ----- hdl/ovb_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Carries the side information alongside; uses ovb_pkg.
`timescale 1ns / 1ps

module ovb_divider #(
  parameter int COLUMN_BITS = ovb_pkg::COLUMN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  num_a,
  input  logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  num_b,
  input  ovb_pkg::side_t                              in_side,
  input  logic [COLUMN_BITS-1:0]                      divisor,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  quot_a,
  output logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  quot_b,
  output ovb_pkg::side_t                              out_side
);

  localparam int QW = ovb_pkg::PIXEL_BITS + COLUMN_BITS;
  localparam int CB = COLUMN_BITS;

  // Entry k holds the stage register that has resolved k + 1 quotient bits.
  logic                vld         [QW];
  logic                rdy         [QW];
  logic [CB-1:0]       rem_a       [QW];
  logic [CB-1:0]       rem_b       [QW];
  logic [QW-1:0]       numq_a      [QW];
  logic [QW-1:0]       numq_b      [QW];
  ovb_pkg::side_t      side        [QW];

  logic                vld_prev    [QW];
  ovb_pkg::side_t      side_prev   [QW];
  logic [CB+QW-1:0]    step_a_next [QW];
  logic [CB+QW-1:0]    step_b_next [QW];

  function automatic logic [CB+QW-1:0] div_step(input logic [CB-1:0] rem,
                                                input logic [QW-1:0] numq,
                                                input logic [CB-1:0] dvs);
    logic [CB:0] sh;
    logic [CB:0] df;
    logic        ge;
    sh = {rem, numq[QW-1]};
    df = sh - {1'b0, dvs};
    ge = (sh >= {1'b0, dvs});
    div_step = {(ge ? df[CB-1:0] : sh[CB-1:0]), numq[QW-2:0], ge};
  endfunction

  always_comb begin
    rdy[QW-1] = !vld[QW-1] || out_ready;
    for (int k = QW - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    vld_prev[0] = in_valid;
    side_prev[0] = in_side;
    step_a_next[0] = div_step('0, num_a, divisor);
    step_b_next[0] = div_step('0, num_b, divisor);
    for (int k = 1; k < QW; k++) begin
      vld_prev[k] = vld[k-1];
      side_prev[k] = side[k-1];
      step_a_next[k] = div_step(rem_a[k-1], numq_a[k-1], divisor);
      step_b_next[k] = div_step(rem_b[k-1], numq_b[k-1], divisor);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld_prev[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k] && vld_prev[k]) begin
        rem_a[k] <= step_a_next[k][CB+QW-1:QW];
        rem_b[k] <= step_b_next[k][CB+QW-1:QW];
        numq_a[k] <= step_a_next[k][QW-1:0];
        numq_b[k] <= step_b_next[k][QW-1:0];
        side[k] <= side_prev[k];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot_a = numq_a[QW-1];
  assign quot_b = numq_b[QW-1];
  assign out_side = side[QW-1];

  a_rem_a_bound : assert property (@(posedge clk) disable iff (rst)
    (vld[QW-1] && side[QW-1].sel == ovb_pkg::SEL_MIX) |-> (rem_a[QW-1] < divisor))
    else $error("source lane remainder not below divisor");

  a_rem_b_bound : assert property (@(posedge clk) disable iff (rst)
    (vld[QW-1] && side[QW-1].sel == ovb_pkg::SEL_MIX) |-> (rem_b[QW-1] < divisor))
    else $error("mosaic lane remainder not below divisor");

endmodule

// ----- hdl/ovb_back.sv -----
// Back end: signed sum of both quotients, saturation, selection and result register.
// Uses ovb_pkg.
`timescale 1ns / 1ps

module ovb_back #(
  parameter int COLUMN_BITS = ovb_pkg::COLUMN_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  quot_a,
  input  logic [ovb_pkg::PIXEL_BITS+COLUMN_BITS-1:0]  quot_b,
  input  ovb_pkg::side_t                              in_side,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [ovb_pkg::PIXEL_BITS-1:0]              pixel_out
);

  localparam int QW = ovb_pkg::PIXEL_BITS + COLUMN_BITS;
  localparam int SUMW = QW + 2;

  logic signed [SUMW-1:0]          term_a;
  logic signed [SUMW-1:0]          term_b;
  logic signed [SUMW-1:0]          sum;
  logic [ovb_pkg::PIXEL_BITS-1:0]  mix;
  logic [ovb_pkg::PIXEL_BITS-1:0]  pixel_next;

  assign term_a = signed'(SUMW'(quot_a));
  assign term_b = in_side.neg ? -signed'(SUMW'(quot_b)) : signed'(SUMW'(quot_b));
  assign sum = term_a + term_b;

  always_comb begin
    if (sum < 0) begin
      mix = '0;
    end else if (sum > signed'(SUMW'(ovb_pkg::PIXEL_MAX))) begin
      mix = ovb_pkg::PIXEL_MAX;
    end else begin
      mix = sum[ovb_pkg::PIXEL_BITS-1:0];
    end
  end

  always_comb begin
    case (in_side.sel)
      ovb_pkg::SEL_DST: pixel_next = in_side.dst;
      ovb_pkg::SEL_MIX: pixel_next = mix;
      default:          pixel_next = in_side.src;
    endcase
  end

  assign in_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pixel_out <= pixel_next;
    end
  end

  a_keep_dst : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_side.sel == ovb_pkg::SEL_DST)
      |=> (pixel_out == $past(in_side.dst)))
    else $error("kept mosaic sample not passed through");

endmodule

// ----- hdl/overlap_linear_blend_top.sv -----
// Top level of the overlap linear blend: configuration registers and the pipeline.
// Instantiates ovb_front, ovb_divider and ovb_back; uses ovb_pkg.
//
//   Channel   Signals                                 Direction
//   pixel     pix_valid, pix_stall, src_pixel,        in
//             pano_pixel, column
//   result    res_valid, res_stall, pixel_out         out
//   config    cfg_we, cfg_index, cfg_data             in
//
// One beat enters per clock when nothing is held up.
// A beat passes the front-end stages, then the divider, which resolves one
// quotient bit per stage, then the result register.
// Reset clears all valid bits and loads the register defaults.
// A stalled result holds in the output register while empty stages upstream
// keep filling, so the pixel channel stalls only once the whole pipe is full.
`timescale 1ns / 1ps

module overlap_linear_blend_top #(
  parameter int COLUMN_BITS = ovb_pkg::COLUMN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  logic [ovb_pkg::PIXEL_BITS-1:0]      src_pixel,
  input  logic [ovb_pkg::PIXEL_BITS-1:0]      pano_pixel,
  input  logic [COLUMN_BITS-1:0]              column,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [ovb_pkg::PIXEL_BITS-1:0]      pixel_out,
  input  logic                                cfg_we,
  input  logic [ovb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ovb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int QW = ovb_pkg::PIXEL_BITS + COLUMN_BITS;

  logic [COLUMN_BITS-1:0] overlap_width;
  logic [COLUMN_BITS-1:0] blend_width;
  logic                   first_image;

  logic                   front_ready;
  logic                   prod_valid;
  logic                   prod_ready;
  logic [QW-1:0]          prod_a;
  logic [QW-1:0]          prod_b;
  ovb_pkg::side_t         prod_side;
  logic                   quot_valid;
  logic                   quot_ready;
  logic [QW-1:0]          quot_a;
  logic [QW-1:0]          quot_b;
  ovb_pkg::side_t         quot_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_width <= COLUMN_BITS'(1);
      blend_width <= '0;
      first_image <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ovb_pkg::REG_OVERLAP_WIDTH: overlap_width <= COLUMN_BITS'(cfg_data);
        ovb_pkg::REG_BLEND_WIDTH:   blend_width <= COLUMN_BITS'(cfg_data);
        ovb_pkg::REG_FIRST_IMAGE:   first_image <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign pix_stall = !front_ready;

  ovb_front #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix_valid),
    .in_ready   (front_ready),
    .src        (src_pixel),
    .dst        (pano_pixel),
    .col        (column),
    .overlap    (overlap_width),
    .blend      (blend_width),
    .first      (first_image),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_a     (prod_a),
    .prod_b     (prod_b),
    .prod_side  (prod_side)
  );

  ovb_divider #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .num_a     (prod_a),
    .num_b     (prod_b),
    .in_side   (prod_side),
    .divisor   (overlap_width),
    .out_valid (quot_valid),
    .out_ready (quot_ready),
    .quot_a    (quot_a),
    .quot_b    (quot_b),
    .out_side  (quot_side)
  );

  ovb_back #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quot_valid),
    .in_ready  (quot_ready),
    .quot_a    (quot_a),
    .quot_b    (quot_b),
    .in_side   (quot_side),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .pixel_out (pixel_out)
  );

endmodule

// ----- bench/overlap_linear_blend_top_tb.sv -----
// Self-checking bench for overlap_linear_blend_top: it predicts every pixel beat and checks it.
// Depends on ovb_pkg and the block's RTL; it needs no other file.
`timescale 1ns / 1ps

module overlap_linear_blend_top_tb;

  localparam int COL_BITS = 12;
  localparam int COL_MAX = (1 << COL_BITS) - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 150;

  typedef struct {
    logic [ovb_pkg::PIXEL_BITS-1:0] src;
    logic [ovb_pkg::PIXEL_BITS-1:0] pano;
    logic [COL_BITS-1:0]            col;
  } pixel_beat_t;

  typedef struct {
    int   overlap;
    int   blend;
    logic first;
  } blend_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pix_valid = 1'b0;
  logic pix_stall;
  logic [ovb_pkg::PIXEL_BITS-1:0] src_pixel = '0;
  logic [ovb_pkg::PIXEL_BITS-1:0] pano_pixel = '0;
  logic [COL_BITS-1:0] column = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [ovb_pkg::PIXEL_BITS-1:0] pixel_out;
  logic cfg_we = 1'b0;
  logic [ovb_pkg::CFG_INDEX_BITS-1:0] cfg_index = ovb_pkg::REG_OVERLAP_WIDTH;
  logic [ovb_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  pixel_beat_t pixels_to_send[$];
  logic [ovb_pkg::PIXEL_BITS-1:0] expected_pixels[$];
  blend_cfg_t blend_cfg = '{overlap: 1, blend: 0, first: 1'b1};

  pixel_beat_t next_beat;
  logic [ovb_pkg::PIXEL_BITS-1:0] want_pixel;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  logic long_hold_req = 1'b0;
  logic stall_next;
  int idle_cycles = 0;
  int beats_in = 0;
  int beats_out = 0;
  int setting_count = 0;
  int error_count = 0;

  overlap_linear_blend_top #(.COLUMN_BITS(COL_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .src_pixel(src_pixel),
    .pano_pixel(pano_pixel),
    .column(column),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .pixel_out(pixel_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ovb_pkg::PIXEL_BITS-1:0] blend_pixel(input pixel_beat_t b);
    int ov;
    int bl;
    int col;
    int band_lo;
    int band_hi;
    int mix;
    ov = blend_cfg.overlap;
    bl = blend_cfg.blend;
    col = int'(b.col);
    band_lo = (ov - bl) >>> 1;
    band_hi = (ov + bl) >>> 1;
    if (blend_cfg.first) begin
      mix = b.src;
    end else if (col < band_lo) begin
      mix = b.pano;
    end else if (col < band_hi) begin
      if (ov == 0) begin
        mix = b.src;
      end else begin
        mix = (int'(b.src) * col) / ov + (int'(b.pano) * (ov - col)) / ov;
      end
    end else begin
      mix = b.src;
    end
    if (mix < 0) begin
      mix = 0;
    end else if (mix > 255) begin
      mix = 255;
    end
    return mix[ovb_pkg::PIXEL_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sender: bursts of random length separated by random gaps; a stalled beat holds.
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        next_beat.src = src_pixel;
        next_beat.pano = pano_pixel;
        next_beat.col = column;
        expected_pixels.push_back(blend_pixel(next_beat));
        beats_in++;
      end
      if (pix_valid && pix_stall) begin
        pix_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        pix_valid <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        next_beat = pixels_to_send.pop_front();
        src_pixel <= next_beat.src;
        pano_pixel <= next_beat.pano;
        column <= next_beat.col;
        pix_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result beat and stalls on a pattern of its own.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        beats_out++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result beat, pixel_out", pixel_out, -1);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (pixel_out !== want_pixel) begin
            report_mismatch("pixel_out", pixel_out, want_pixel);
          end
        end
      end
      if (long_hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          3: stall_next = (mode_left % 8) < 3;
          default: stall_next = 1'b0;
        endcase
      end
      res_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pixels_to_send.size() != 0 || expected_pixels.size() != 0 || pix_valid) begin
      @(negedge clk);
    end
  endtask

  task automatic write_blend_regs(input int ov, input int bl, input logic first);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ovb_pkg::REG_OVERLAP_WIDTH;
    cfg_data <= ovb_pkg::CFG_DATA_BITS'(ov);
    @(posedge clk);
    cfg_index <= ovb_pkg::REG_BLEND_WIDTH;
    cfg_data <= ovb_pkg::CFG_DATA_BITS'(bl);
    @(posedge clk);
    cfg_index <= ovb_pkg::REG_FIRST_IMAGE;
    cfg_data <= ovb_pkg::CFG_DATA_BITS'(first);
    @(posedge clk);
    cfg_we <= 1'b0;
    blend_cfg.overlap = ov;
    blend_cfg.blend = bl;
    blend_cfg.first = first;
    setting_count++;
  endtask

  task automatic push_pixel(input int src, input int pano, input int col);
    pixel_beat_t b;
    b.src = ovb_pkg::PIXEL_BITS'(src);
    b.pano = ovb_pkg::PIXEL_BITS'(pano);
    b.col = COL_BITS'(col);
    pixels_to_send.push_back(b);
  endtask

  // Most columns land near the band edges or the overlap, or inside the band, where the cases split.
  task automatic push_random_pixels(input int count);
    int lo;
    int hi;
    int col;
    int src;
    int pano;
    lo = (blend_cfg.overlap - blend_cfg.blend) >>> 1;
    hi = (blend_cfg.overlap + blend_cfg.blend) >>> 1;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: col = $urandom_range(0, COL_MAX);
        3: col = blend_cfg.overlap + $urandom_range(0, 6) - 3;
        4, 5: col = lo + $urandom_range(0, 6) - 3;
        6, 7: col = hi + $urandom_range(0, 6) - 3;
        default: col = $urandom_range(lo < 0 ? 0 : lo, hi < 0 ? 0 : hi);
      endcase
      if (col < 0) col = 0;
      if (col > COL_MAX) col = COL_MAX;
      src = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      pano = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
      push_pixel(src, pano, col);
    end
  endtask

  initial begin
    int ov;
    int bl;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings copy the source everywhere.
    push_pixel(0, 255, 0);
    push_pixel(255, 0, COL_MAX);
    wait_drained();

    // Band from column 4 up to column 12: keep, mix, then take the source.
    write_blend_regs(16, 8, 1'b0);
    push_pixel(0, 255, 0);
    push_pixel(255, 0, 3);
    push_pixel(255, 0, 4);
    push_pixel(255, 255, 8);
    push_pixel(0, 255, 11);
    push_pixel(255, 0, 12);
    push_pixel(0, 255, 16);
    push_pixel(170, 85, 2048);
    wait_drained();

    // Blend wider than the overlap: the band starts below zero and runs past the overlap,
    // so the second term turns negative and the sum saturates both ways.
    write_blend_regs(3, 8, 1'b0);
    push_pixel(255, 0, 0);
    push_pixel(255, 0, 4);
    push_pixel(0, 255, 4);
    push_pixel(100, 200, 5);
    push_pixel(200, 100, 2);
    wait_drained();

    // Odd overlap with a narrow band, then the widest and the narrowest settings.
    write_blend_regs(7, 2, 1'b0);
    push_pixel(9, 250, 1);
    push_pixel(9, 250, 2);
    push_pixel(9, 250, 3);
    push_pixel(9, 250, 4);
    wait_drained();
    write_blend_regs(COL_MAX, COL_MAX, 1'b0);
    push_pixel(255, 255, COL_MAX - 1);
    push_pixel(255, 0, COL_MAX);
    push_pixel(123, 45, 0);
    wait_drained();
    write_blend_regs(1, 0, 1'b0);
    push_pixel(255, 0, 0);
    push_pixel(0, 255, 1);
    wait_drained();

    // The receiver holds off long enough for the pipe to fill and stall the sender.
    write_blend_regs(40, 30, 1'b0);
    long_hold_req = 1'b1;
    push_random_pixels(200);
    wait_drained();

    for (int phase = 0; phase < 14; phase++) begin
      case ($urandom_range(0, 5))
        0: begin
          ov = $urandom_range(1, COL_MAX);
          bl = $urandom_range(0, COL_MAX);
        end
        4: begin
          ov = $urandom_range(1, 32);
          bl = ov + $urandom_range(0, 40);
        end
        5: begin
          ov = $urandom_range(0, 1) ? COL_MAX : 1;
          bl = $urandom_range(0, 1) ? COL_MAX : 0;
        end
        default: begin
          ov = $urandom_range(1, 64);
          bl = $urandom_range(0, 80);
        end
      endcase
      write_blend_regs(ov, bl, $urandom_range(0, 7) == 0);
      push_random_pixels(120);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch("results still outstanding", 0, expected_pixels.size());
    end
    $display("Ran %0d pixel beats in and %0d out across %0d register settings,", beats_in,
             beats_out, setting_count);
    $display("covering copy, keep, band mix, negative band start and saturation.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
